@@ rtl/core/svl_pkg.sv @@
// shared types, register indexes and operation codes for the setpoint limiter
`default_nettype none
package svl_pkg;

	// period fraction bits
	localparam int DT_BITS = 16;

	// configuration port widths
	localparam int CFG_W = 32;
	localparam int IDX_W = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_STEP_TIME   = 2'd0;
	localparam logic [IDX_W-1:0] REG_VEL_LIMIT   = 2'd1;
	localparam logic [IDX_W-1:0] REG_ACCEL_LIMIT = 2'd2;

	// register reset values
	localparam logic [15:0] STEP_TIME_RST   = 16'd1311;
	localparam logic [30:0] VEL_LIMIT_RST   = 31'd65536;
	localparam logic [30:0] ACCEL_LIMIT_RST = 31'd32768;

	// datapath operations
	localparam logic [3:0] OP_VX   = 4'd0;
	localparam logic [3:0] OP_VY   = 4'd1;
	localparam logic [3:0] OP_SQA  = 4'd2;
	localparam logic [3:0] OP_SQB  = 4'd3;
	localparam logic [3:0] OP_SQL  = 4'd4;
	localparam logic [3:0] OP_ROOT = 4'd5;
	localparam logic [3:0] OP_SCA  = 4'd6;
	localparam logic [3:0] OP_SCB  = 4'd7;
	localparam logic [3:0] OP_AX   = 4'd8;
	localparam logic [3:0] OP_AY   = 4'd9;
	localparam logic [3:0] OP_VUX  = 4'd10;
	localparam logic [3:0] OP_VUY  = 4'd11;
	localparam logic [3:0] OP_PUX  = 4'd12;
	localparam logic [3:0] OP_PUY  = 4'd13;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
	} out_item_t;

	typedef struct packed {
		logic [15:0] step_time;
		logic [30:0] vel_limit;
		logic [30:0] accel_limit;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       start;
		logic [3:0] op;
		logic       ph;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic over;
		logic dt_zero;
		logic is_rst;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/svl_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module svl_mul #(
	parameter int AW = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            go,
	input  wire logic [AW-1:0]   a,
	input  wire logic [AW-1:0]   b,
	output logic                 done,
	output logic [2*AW-1:0]      p
);
	localparam int CW = $clog2(AW + 1);

	logic [2*AW-1:0] mc_q;
	logic [2*AW-1:0] acc_q;
	logic [AW-1:0]   mp_q;
	logic [CW-1:0]   cnt_q;
	logic            done_q;

	// shift and add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q   <= '0;
			acc_q  <= '0;
			mp_q   <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				mc_q  <= (2*AW)'(a);
				mp_q  <= b;
				acc_q <= '0;
				cnt_q <= CW'(AW);
			end else if (cnt_q != '0) begin
				if (mp_q[0]) begin
					acc_q <= acc_q + mc_q;
				end
				mc_q   <= mc_q << 1;
				mp_q   <= mp_q >> 1;
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule
`default_nettype wire

@@ rtl/core/svl_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module svl_div #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	// partial remainder with next dividend bit
	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				quo_q <= num;
				den_q <= den;
				rem_q <= '0;
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				if (fits) begin
					rem_q <= DW'(trial - {1'b0, den_q});
				end else begin
					rem_q <= DW'(trial);
				end
				quo_q  <= {quo_q[NW-2:0], fits};
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

@@ rtl/core/svl_sqrt.sv @@
// digit-by-digit floor square root, one root bit per cycle
`default_nettype none
module svl_sqrt #(
	parameter int SW = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            go,
	input  wire logic [SW-1:0]   x,
	output logic                 done,
	output logic [SW/2-1:0]      root
);
	localparam int HW = SW / 2;
	localparam int RW = HW + 2;
	localparam int CW = $clog2(HW + 1);

	logic [SW-1:0] x_q;
	logic [RW-1:0] rem_q;
	logic [HW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [RW-1:0] cur;
	logic [RW-1:0] trial;
	logic          fits;

	// bring down two bits, try root*4+1
	always_comb begin
		cur   = {rem_q[RW-3:0], x_q[SW-1:SW-2]};
		trial = {root_q, 2'b01};
		fits  = (cur >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				x_q    <= x;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CW'(HW);
			end else if (cnt_q != '0) begin
				rem_q  <= fits ? (cur - trial) : cur;
				root_q <= {root_q[HW-2:0], fits};
				x_q    <= x_q << 2;
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

@@ rtl/core/svl_ctrl.sv @@
// controller state machine sequencing the datapath operations
`default_nettype none
module svl_ctrl
	import svl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_VX   = 4'd1;
	localparam logic [3:0] S_VY   = 4'd2;
	localparam logic [3:0] S_SQA  = 4'd3;
	localparam logic [3:0] S_SQB  = 4'd4;
	localparam logic [3:0] S_SQL  = 4'd5;
	localparam logic [3:0] S_ROOT = 4'd6;
	localparam logic [3:0] S_SCA  = 4'd7;
	localparam logic [3:0] S_SCB  = 4'd8;
	localparam logic [3:0] S_AX   = 4'd9;
	localparam logic [3:0] S_AY   = 4'd10;
	localparam logic [3:0] S_VUX  = 4'd11;
	localparam logic [3:0] S_VUY  = 4'd12;
	localparam logic [3:0] S_PUX  = 4'd13;
	localparam logic [3:0] S_PUY  = 4'd14;
	localparam logic [3:0] S_EMIT = 4'd15;

	logic [3:0] state_q;
	logic       issued_q;
	logic       ph_q;
	logic       out_valid_q;
	logic       fire;
	logic       emit;
	logic       working;
	logic [3:0] op;
	logic [3:0] after_lim;

	// state to operation decode
	always_comb begin
		unique case (state_q)
			S_VX:    op = OP_VX;
			S_VY:    op = OP_VY;
			S_SQA:   op = OP_SQA;
			S_SQB:   op = OP_SQB;
			S_SQL:   op = OP_SQL;
			S_ROOT:  op = OP_ROOT;
			S_SCA:   op = OP_SCA;
			S_SCB:   op = OP_SCB;
			S_AX:    op = OP_AX;
			S_AY:    op = OP_AY;
			S_VUX:   op = OP_VUX;
			S_VUY:   op = OP_VUY;
			S_PUX:   op = OP_PUX;
			S_PUY:   op = OP_PUY;
			default: op = OP_VX;
		endcase
	end

	// handshakes and commands
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		fire      = in_valid && in_ready;
		emit      = (state_q == S_EMIT) && (!out_valid_q || out_ready);
		working   = (state_q != S_IDLE) && (state_q != S_EMIT);
		after_lim = ph_q ? S_VUX : S_AX;
		cmd.load  = fire;
		cmd.start = working && !issued_q;
		cmd.op    = op;
		cmd.ph    = ph_q;
		cmd.emit  = emit;
		out_valid = out_valid_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
			ph_q     <= 1'b0;
		end else begin
			if (cmd.start) begin
				issued_q <= 1'b1;
			end
			if (state_q == S_IDLE) begin
				if (fire) begin
					ph_q <= 1'b0;
					if (!stat.is_rst) begin
						state_q <= stat.dt_zero ? S_EMIT : S_VX;
					end
				end
			end else if (state_q == S_EMIT) begin
				if (emit) begin
					state_q <= S_IDLE;
				end
			end else if (stat.done) begin
				issued_q <= 1'b0;
				unique case (state_q)
					S_VX:   state_q <= S_VY;
					S_VY:   state_q <= S_SQA;
					S_SQA:  state_q <= S_SQB;
					S_SQB:  state_q <= S_SQL;
					S_SQL:  state_q <= stat.over ? S_ROOT : after_lim;
					S_ROOT: state_q <= S_SCA;
					S_SCA:  state_q <= S_SCB;
					S_SCB:  state_q <= after_lim;
					S_AX:   state_q <= S_AY;
					S_AY: begin
						state_q <= S_SQA;
						ph_q    <= 1'b1;
					end
					S_VUX:  state_q <= S_VUY;
					S_VUY:  state_q <= S_PUX;
					S_PUX:  state_q <= S_PUY;
					S_PUY:  state_q <= S_EMIT;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// output beat holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken beat");
	a_rst_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && stat.is_rst) |=> (state_q == S_IDLE))
		else $error("reset item started work");
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !stat.done)
		else $error("datapath done with no operation pending");
	a_done_working: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (working && issued_q))
		else $error("datapath done outside an operation");
`endif
endmodule
`default_nettype wire

@@ rtl/core/svl_dp.sv @@
// datapath: state registers, operand selection, shared multiplier, divider and root
`default_nettype none
module svl_dp
	import svl_pkg::*;
#(
	parameter int W = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire in_item_t in_data,
	input  wire dp_cmd_t  cmd,
	output dp_stat_t      stat,
	output out_item_t     out_data
);
	localparam int AW = (W > 31) ? W : 31;
	localparam int PW = 2 * AW;
	localparam int EW = (W > 32) ? W : 32;
	localparam logic [PW-1:0]        VMAX_P   = (PW'(1) << (W - 1)) - PW'(1);
	localparam logic [W:0]           VMAX_D   = {2'b00, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  VMAX_W   = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  VMIN_W   = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [EW-1:0] VMAX_E   = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [EW-1:0] VMIN_E   = ~VMAX_E;
	localparam logic signed [EW-1:0] O32MAX_E = {{(EW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [EW-1:0] O32MIN_E = ~O32MAX_E;

	function automatic logic [W-1:0] magw(input logic signed [W-1:0] v);
		magw = v[W-1] ? W'(-v) : W'(v);
	endfunction

	function automatic logic signed [W-1:0] ssat(input logic neg, input logic [PW-1:0] m);
		logic [PW-1:0] cap;
		logic [PW-1:0] mm;
		cap  = VMAX_P + PW'(neg);
		mm   = (m > cap) ? cap : m;
		ssat = neg ? W'(-mm) : W'(mm);
	endfunction

	function automatic logic signed [W-1:0] clampw(input logic [W:0] v);
		if (v[W] != v[W-1]) begin
			clampw = v[W] ? VMIN_W : VMAX_W;
		end else begin
			clampw = v[W-1:0];
		end
	endfunction

	function automatic logic signed [W-1:0] inclamp(input logic signed [31:0] v);
		logic signed [EW-1:0] e;
		e = EW'(v);
		if (e > VMAX_E) begin
			inclamp = W'(VMAX_E);
		end else if (e < VMIN_E) begin
			inclamp = W'(VMIN_E);
		end else begin
			inclamp = W'(e);
		end
	endfunction

	function automatic logic [31:0] out32(input logic signed [W-1:0] v);
		logic signed [EW-1:0] e;
		e = EW'(v);
		if (e > O32MAX_E) begin
			out32 = 32'(O32MAX_E);
		end else if (e < O32MIN_E) begin
			out32 = 32'(O32MIN_E);
		end else begin
			out32 = 32'(e);
		end
	endfunction

	logic signed [W-1:0] px_q, py_q, vx_q, vy_q;
	logic signed [W-1:0] ca_q, cb_q;
	logic [31:0]         xr_q, yr_q, z_q;
	logic [PW-1:0]       acc_q;
	logic [AW-1:0]       n_q;
	logic                over_q;
	logic                neg_q;
	logic [3:0]          op_q;
	logic                done_q;
	logic                mul_go_q, div_go_q, sq_go_q;
	logic [AW-1:0]       mul_a_q, mul_b_q;
	logic [PW-1:0]       div_num_q;
	logic [AW-1:0]       div_den_q;
	out_item_t           out_q;

	logic                mul_done, div_done, sq_done;
	logic [PW-1:0]       mul_p, div_q;
	logic [AW-1:0]       sq_root;

	logic signed [W-1:0] xin, yin, dp_a, dp_b, base;
	logic [W:0]          dd, dm;
	logic                dneg, dsat;
	logic [AW-1:0]       lim, ma, mb;
	logic                mneg;
	logic signed [W-1:0] tsat, upd;

	// operand selection for the issued operation
	always_comb begin
		xin  = inclamp(xr_q);
		yin  = inclamp(yr_q);
		lim  = cmd.ph ? AW'(cfg.accel_limit) : AW'(cfg.vel_limit);
		dp_a = xin;
		dp_b = px_q;
		ma   = AW'(magw(ca_q));
		mb   = AW'(magw(ca_q));
		mneg = ca_q[W-1];
		unique case (cmd.op) inside
			OP_VX: begin
				dp_a = xin;
				dp_b = px_q;
			end
			OP_VY: begin
				dp_a = yin;
				dp_b = py_q;
			end
			OP_AX: begin
				dp_a = ca_q;
				dp_b = vx_q;
			end
			OP_AY: begin
				dp_a = cb_q;
				dp_b = vy_q;
			end
			OP_SQB: begin
				ma = AW'(magw(cb_q));
				mb = AW'(magw(cb_q));
			end
			OP_SQL: begin
				ma = lim;
				mb = lim;
			end
			OP_SCA: begin
				mb = lim;
			end
			OP_SCB: begin
				ma   = AW'(magw(cb_q));
				mb   = lim;
				mneg = cb_q[W-1];
			end
			OP_VUX: begin
				mb = AW'(cfg.step_time);
			end
			OP_VUY: begin
				ma   = AW'(magw(cb_q));
				mb   = AW'(cfg.step_time);
				mneg = cb_q[W-1];
			end
			OP_PUX: begin
				ma   = AW'(magw(vx_q));
				mb   = AW'(cfg.step_time);
				mneg = vx_q[W-1];
			end
			OP_PUY: begin
				ma   = AW'(magw(vy_q));
				mb   = AW'(cfg.step_time);
				mneg = vy_q[W-1];
			end
			default: begin
			end
		endcase
		dd   = {dp_a[W-1], dp_a} - {dp_b[W-1], dp_b};
		dneg = dd[W];
		dm   = dneg ? -dd : dd;
		dsat = (dm > VMAX_D);
	end

	// state update from a period-scaled product
	always_comb begin
		tsat = ssat(neg_q, mul_p >> DT_BITS);
		case (op_q) inside
			OP_VUY:  base = vy_q;
			OP_PUX:  base = px_q;
			OP_PUY:  base = py_q;
			default: base = vx_q;
		endcase
		upd = clampw({base[W-1], base} + {tsat[W-1], tsat});
	end

	// operation launch and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q      <= '0;
			py_q      <= '0;
			vx_q      <= '0;
			vy_q      <= '0;
			ca_q      <= '0;
			cb_q      <= '0;
			xr_q      <= '0;
			yr_q      <= '0;
			z_q       <= '0;
			acc_q     <= '0;
			n_q       <= '0;
			over_q    <= 1'b0;
			neg_q     <= 1'b0;
			op_q      <= OP_VX;
			done_q    <= 1'b0;
			mul_go_q  <= 1'b0;
			div_go_q  <= 1'b0;
			sq_go_q   <= 1'b0;
			mul_a_q   <= '0;
			mul_b_q   <= '0;
			div_num_q <= '0;
			div_den_q <= '0;
			out_q     <= '0;
		end else begin
			done_q   <= 1'b0;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			sq_go_q  <= 1'b0;

			// input beat capture, reset items load the position
			if (cmd.load) begin
				xr_q <= in_data.in_x;
				yr_q <= in_data.in_y;
				z_q  <= in_data.in_z;
				if (in_data.cmd) begin
					px_q <= inclamp(in_data.in_x);
					py_q <= inclamp(in_data.in_y);
					vx_q <= '0;
					vy_q <= '0;
				end
			end

			if (cmd.start) begin
				op_q <= cmd.op;
				unique case (cmd.op) inside
					OP_VX, OP_VY, OP_AX, OP_AY: begin
						neg_q <= dneg;
						if (dsat) begin
							if (cmd.op == OP_VX || cmd.op == OP_AX) begin
								ca_q <= dneg ? VMIN_W : VMAX_W;
							end else begin
								cb_q <= dneg ? VMIN_W : VMAX_W;
							end
							done_q <= 1'b1;
						end else begin
							div_go_q  <= 1'b1;
							div_num_q <= PW'(dm) << DT_BITS;
							div_den_q <= AW'(cfg.step_time);
						end
					end
					OP_ROOT: begin
						sq_go_q <= 1'b1;
					end
					default: begin
						mul_go_q <= 1'b1;
						mul_a_q  <= ma;
						mul_b_q  <= mb;
						neg_q    <= mneg;
					end
				endcase
			end

			if (mul_done) begin
				case (op_q) inside
					OP_SQA: begin
						acc_q  <= mul_p;
						done_q <= 1'b1;
					end
					OP_SQB: begin
						acc_q  <= acc_q + mul_p;
						done_q <= 1'b1;
					end
					OP_SQL: begin
						over_q <= (acc_q > mul_p);
						done_q <= 1'b1;
					end
					OP_SCA, OP_SCB: begin
						div_go_q  <= 1'b1;
						div_num_q <= mul_p;
						div_den_q <= n_q;
					end
					OP_VUX: begin
						vx_q   <= upd;
						done_q <= 1'b1;
					end
					OP_VUY: begin
						vy_q   <= upd;
						done_q <= 1'b1;
					end
					OP_PUX: begin
						px_q   <= upd;
						done_q <= 1'b1;
					end
					OP_PUY: begin
						py_q   <= upd;
						done_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end

			if (div_done) begin
				if (op_q == OP_VX || op_q == OP_AX || op_q == OP_SCA) begin
					ca_q <= ssat(neg_q, div_q);
				end else begin
					cb_q <= ssat(neg_q, div_q);
				end
				done_q <= 1'b1;
			end

			if (sq_done) begin
				n_q    <= sq_root;
				done_q <= 1'b1;
			end

			// result register
			if (cmd.emit) begin
				out_q.out_z <= z_q;
				if (cfg.step_time == '0) begin
					out_q.out_x <= xr_q;
					out_q.out_y <= yr_q;
				end else begin
					out_q.out_x <= out32(px_q);
					out_q.out_y <= out32(py_q);
				end
			end
		end
	end

	svl_mul #(.AW(AW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	svl_div #(.NW(PW), .DW(AW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quo    (div_q)
	);

	svl_sqrt #(.SW(PW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sq_go_q),
		.x      (acc_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// status back to the controller
	always_comb begin
		stat.done    = done_q;
		stat.over    = over_q;
		stat.dt_zero = (cfg.step_time == '0);
		stat.is_rst  = in_data.cmd;
		out_data     = out_q;
	end
endmodule
`default_nettype wire

@@ rtl/core/setpoint_velocity_accel_limiter.sv @@
// top level: configuration registers, controller and datapath of the setpoint limiter
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_data (cmd, in_x, in_y, in_z)
//   out      output     out_valid/out_ready  out_data (out_x, out_y, out_z)
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a step item's duration is set by the shared bit-serial multiplier, divider and root
// unit, and by whether the norm limits are hit; a saturated difference skips its divide.
// a reset item starts no work and gives no result; a zero period goes straight to the
// output register.
// one item is in work at a time; the next beat is taken once the result is in the
// output register, which holds it while out_ready is low.
// arst_n clears the state to zero and the registers to their defaults.
`default_nettype none
module setpoint_velocity_accel_limiter
	import svl_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_item_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_item_t             out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);
	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_time   <= STEP_TIME_RST;
			cfg_q.vel_limit   <= VEL_LIMIT_RST;
			cfg_q.accel_limit <= ACCEL_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEP_TIME:   cfg_q.step_time   <= cfg_data[15:0];
				REG_VEL_LIMIT:   cfg_q.vel_limit   <= cfg_data[30:0];
				REG_ACCEL_LIMIT: cfg_q.accel_limit <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	svl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	svl_dp #(.W(VALUE_WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);
endmodule
`default_nettype wire
